>>> hdl/round_robin_chunk_requester_unit_assert.svh
// Assertion macros for the requester modules; only rrc_back includes them.
`ifndef ROUND_ROBIN_CHUNK_REQUESTER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_CHUNK_REQUESTER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define RRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrc_pkg;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned ID_W = 16;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned RATE_W = 32;
	localparam int unsigned WIN_W = 16;
	localparam int unsigned MA_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_REQ = 2'd1,
		CMD_RET = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MAX_ACTIVE = 2'd0,
		REG_MAX_RATE = 2'd1,
		REG_WINDOW = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cmd_t cmd;
		logic [ID_W-1:0] file_id;
		logic [CNT_W-1:0] chunk_total;
	} item_t;

	typedef struct packed {
		logic request_valid;
		logic [ID_W-1:0] req_file;
		logic [CNT_W-1:0] req_chunk;
		logic [RATE_W-1:0] send_rate;
		logic [CNT_W-1:0] outstanding;
		logic all_done;
		logic error_flag;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_FILL,
		ST_ISSUE,
		ST_SHIFT,
		ST_OUT
	} bstate_t;
endpackage
`default_nettype wire

>>> hdl/round_robin_chunk_requester_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Round-robin chunk requester.
// Input stream s_axis: tuser carries cmd (push, request, return); tdata carries
// file_id in bits 15:0 and chunk_total in bits 31:16. Output stream m_axis gives
// one result beat per input beat. Configuration is a plain write port: index 0
// max_active, 1 max_rate (also reloads the rate), 2 window_size.
// Items run one at a time through the back end. Push, return and unused
// commands are taken in ST_IDLE, then ST_OUT lets status settle and shows the beat.
// A request goes through ST_FILL, with one ST_RD per file moved from the stack
// into the table (one registered stack read each), then, if the table holds an entry,
// ST_ISSUE and ST_SHIFT, which closes up to ACTIVE_DEPTH - 1 entries when one completes.
// A result beat is shown once its input has passed the input queue, the take in
// ST_IDLE and the settle step of ST_OUT; the next item starts after it is taken.
// A two-beat input queue lets beats arrive while a result waits on a stalled
// receiver; the result register holds until taken.
// Reset empties stack, table and counters and loads default registers; stack and
// table contents are undefined until written.
module round_robin_chunk_requester_unit #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned ACTIVE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // file_id, chunk_total
	input wire logic [1:0] s_axis_tuser, // cmd
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [87:0] m_axis_tdata, // request_valid, req_file, req_chunk, send_rate,
	                                  // outstanding, all_done, error_flag, zero fill
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	import rrc_pkg::*;

	item_t in_item, q_item;
	result_t res;
	logic q_valid, q_take;

	assign in_item.cmd = cmd_t'(s_axis_tuser);
	assign in_item.file_id = s_axis_tdata[15:0];
	assign in_item.chunk_total = s_axis_tdata[31:16];

	rrc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	rrc_back #(.STACK_DEPTH(STACK_DEPTH), .ACTIVE_DEPTH(ACTIVE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {5'd0, res.error_flag, res.all_done, res.outstanding,
		res.send_rate, res.req_chunk, res.req_file, res.request_valid};
endmodule
`default_nettype wire

>>> hdl/rrc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Input side: takes beats and holds them in a two-entry queue for the back end.
module rrc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire rrc_pkg::item_t in_item,
	output logic q_valid,
	input wire logic q_take,
	output rrc_pkg::item_t q_item
);
	import rrc_pkg::*;

	item_t slot_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_take;
	assign q_item = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_item;
	end
endmodule
`default_nettype wire

>>> hdl/rrc_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_chunk_requester_unit_assert.svh"
// Execution side: stack memory, active table, rate control and result register.
module rrc_back #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned ACTIVE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic q_valid,
	output logic q_take,
	input wire rrc_pkg::item_t q_item,
	output logic out_valid,
	input wire logic out_ready,
	output rrc_pkg::result_t out_res
);
	import rrc_pkg::*;

	localparam int unsigned SP_W = $clog2(STACK_DEPTH);
	localparam int unsigned SC_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AP_W = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
	localparam int unsigned AC_W = $clog2(ACTIVE_DEPTH + 1);

	logic [ID_W+CNT_W-1:0] stack_mem [STACK_DEPTH];
	logic [ID_W+CNT_W-1:0] stk_rd_q;
	logic [ID_W-1:0] tf_q [ACTIVE_DEPTH];
	logic [CNT_W-1:0] tt_q [ACTIVE_DEPTH];
	logic [CNT_W-1:0] tn_q [ACTIVE_DEPTH];

	logic [MA_W-1:0] max_active_q;
	logic [RATE_W-1:0] max_rate_q, rate_q;
	logic [WIN_W-1:0] window_q;
	logic [SC_W-1:0] sc_q;
	logic [AC_W-1:0] ac_q;
	logic [AC_W-1:0] rr_q;
	logic [CNT_W-1:0] pend_q;
	logic [AC_W-1:0] sh_q;
	logic [ID_W-1:0] rf_q;
	logic [CNT_W-1:0] rc_q;
	logic err_q, rv_q;
	bstate_t st_q, st_d;
	result_t res_q;
	logic out_first_q;

	logic [AC_W-1:0] limit;
	logic [5:0] ma_ext;
	logic [AP_W-1:0] rr_idx;
	logic [AP_W-1:0] sh_idx;
	logic [WIN_W:0] hi_thr;
	logic [WIN_W-2:0] lo_thr;
	logic [CNT_W-1:0] pend_inc;
	logic [RATE_W:0] dbl;

	always_comb begin
		ma_ext = {1'b0, max_active_q};
		if (32'(ma_ext) < ACTIVE_DEPTH) limit = AC_W'(ma_ext);
		else limit = AC_W'(ACTIVE_DEPTH);
	end

	assign rr_idx = rr_q[AP_W-1:0];
	assign sh_idx = sh_q[AP_W-1:0];
	assign hi_thr = {window_q, 1'b0};
	assign lo_thr = window_q[WIN_W-1:1];
	assign pend_inc = (pend_q != '1) ? pend_q + 1'b1 : pend_q;
	assign dbl = {rate_q, 1'b0};

	// The first cycle of ST_OUT lets the status fields settle before the beat is shown.
	assign out_valid = (st_q == ST_OUT) && !out_first_q;
	assign out_res = res_q;

	always_comb begin
		st_d = st_q;
		q_take = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_take = 1'b1;
					case (q_item.cmd)
						CMD_REQ: st_d = ST_FILL;
						default: st_d = ST_OUT;
					endcase
				end
			end
			ST_RD: st_d = ST_FILL;
			ST_FILL: begin
				if (ac_q < limit && sc_q != '0) st_d = ST_RD;
				else if (ac_q == '0) st_d = ST_OUT;
				else st_d = ST_ISSUE;
			end
			ST_ISSUE: st_d = ST_SHIFT;
			ST_SHIFT: begin
				if (!rv_q || sh_q + 1'b1 >= ac_q) st_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_valid && out_ready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// Stack memory: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid && q_item.cmd == CMD_PUSH && sc_q < SC_W'(STACK_DEPTH))
			stack_mem[sc_q[SP_W-1:0]] <= {q_item.file_id, q_item.chunk_total};
		if (st_q == ST_FILL) stk_rd_q <= stack_mem[SP_W'(sc_q - 1'b1)];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_RD) begin
			tf_q[ac_q[AP_W-1:0]] <= stk_rd_q[ID_W+CNT_W-1:CNT_W];
			tt_q[ac_q[AP_W-1:0]] <= stk_rd_q[CNT_W-1:0];
			tn_q[ac_q[AP_W-1:0]] <= CNT_W'(1);
		end else if (st_q == ST_ISSUE) begin
			if (tn_q[rr_idx] < tt_q[rr_idx]) tn_q[rr_idx] <= tn_q[rr_idx] + 1'b1;
		end else if (st_q == ST_SHIFT && rv_q && sh_q + 1'b1 < ac_q) begin
			tf_q[sh_idx] <= tf_q[AP_W'(sh_q + 1'b1)];
			tt_q[sh_idx] <= tt_q[AP_W'(sh_q + 1'b1)];
			tn_q[sh_idx] <= tn_q[AP_W'(sh_q + 1'b1)];
		end
		if (st_q == ST_ISSUE) begin
			rf_q <= tf_q[rr_idx];
			rc_q <= tn_q[rr_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q <= MA_W'(16);
			max_rate_q <= 32'd1000000000;
			rate_q <= 32'd1000000000;
			window_q <= 16'd64;
			sc_q <= '0;
			ac_q <= '0;
			rr_q <= '0;
			pend_q <= '0;
			sh_q <= '0;
			err_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_ACTIVE: max_active_q <= cfg_data[MA_W-1:0];
					REG_MAX_RATE: begin
						max_rate_q <= cfg_data;
						rate_q <= cfg_data;
					end
					REG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: begin
					err_q <= 1'b0;
					rv_q <= 1'b0;
					if (q_valid) begin
						case (q_item.cmd)
							CMD_PUSH: begin
								if (sc_q < SC_W'(STACK_DEPTH)) sc_q <= sc_q + 1'b1;
								else err_q <= 1'b1;
							end
							CMD_RET: begin
								if (pend_q == '0) err_q <= 1'b1;
								else pend_q <= pend_q - 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_RD: begin
					sc_q <= sc_q - 1'b1;
					ac_q <= ac_q + 1'b1;
				end
				ST_FILL: begin
					if (!(ac_q < limit && sc_q != '0) && ac_q != '0 && rr_q >= ac_q)
						rr_q <= '0;
				end
				ST_ISSUE: begin
					sh_q <= rr_q;
					if (tn_q[rr_idx] >= tt_q[rr_idx]) rv_q <= 1'b1;
					else rr_q <= rr_q + 1'b1;
					pend_q <= pend_inc;
					if (pend_inc > CNT_W'(hi_thr[CNT_W-1:0]) || hi_thr[WIN_W])
						rate_q <= (pend_inc > hi_thr[CNT_W-1:0] && !hi_thr[WIN_W])
							? rate_q >> 1 : rate_q;
					if (!(32'(pend_inc) > 32'(hi_thr)) && 32'(pend_inc) < 32'(lo_thr)) begin
						if (dbl >= {1'b0, max_rate_q}) rate_q <= max_rate_q;
						else rate_q <= dbl[RATE_W-1:0];
					end
				end
				ST_SHIFT: begin
					if (rv_q) begin
						if (sh_q + 1'b1 < ac_q) sh_q <= sh_q + 1'b1;
						else ac_q <= ac_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_first_q <= 1'b0;
		else out_first_q <= (st_q != ST_OUT && st_d == ST_OUT);
	end

	// Status fields are sampled in the first cycle of ST_OUT, after counts settle.
	always_ff @(posedge clk) begin
		if (st_q != ST_OUT && st_d == ST_OUT) begin
			res_q.request_valid <= (st_q == ST_SHIFT);
			res_q.req_file <= (st_q == ST_SHIFT) ? rf_q : '0;
			res_q.req_chunk <= (st_q == ST_SHIFT) ? rc_q : '0;
		end
		if (out_first_q) begin
			res_q.send_rate <= rate_q;
			res_q.outstanding <= pend_q;
			res_q.all_done <= (sc_q == '0 && ac_q == '0);
			res_q.error_flag <= err_q;
		end
	end

	`RRC_ASSERT_IMP(a_ac_bound, clk, arst_n, 1'b1, ac_q <= AC_W'(ACTIVE_DEPTH), "table overflow")
	`RRC_ASSERT_IMP(a_sc_bound, clk, arst_n, 1'b1, sc_q <= SC_W'(STACK_DEPTH), "stack overflow")
	`RRC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready && !out_first_q, out_valid && $stable(out_res), "result changed while stalled")
endmodule
`default_nettype wire

>>> tb/round_robin_chunk_requester_unit_tb.sv
`timescale 1ns / 1ps
module round_robin_chunk_requester_unit_tb;
	import rrc_pkg::*;

	localparam int unsigned STACK_LIMIT = 64;
	localparam int unsigned TABLE_LIMIT = 16;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	round_robin_chunk_requester_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the scheduler state.
	logic [4:0] sh_max_active;
	logic [31:0] sh_max_rate;
	logic [15:0] sh_window;
	logic [15:0] stk_file [STACK_LIMIT];
	logic [15:0] stk_total [STACK_LIMIT];
	int unsigned stk_count;
	logic [15:0] tbl_file [TABLE_LIMIT];
	logic [15:0] tbl_total [TABLE_LIMIT];
	logic [15:0] tbl_next [TABLE_LIMIT];
	int unsigned tbl_count;
	int unsigned rr_pos;
	logic [15:0] pending;
	logic [31:0] rate;

	result_t expected_results [$];
	int fail_count = 0;
	int gap_pct = 30;
	int stall_pct = 30;
	int n_items = 0, n_issued = 0, n_errors = 0, n_results = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("round_robin_chunk_requester_unit: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		if ($urandom_range(99) >= gap_pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(40, 12);
		return $urandom_range(3, 1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic next_request(inout result_t r);
		int unsigned lim;
		lim = (sh_max_active < TABLE_LIMIT) ? sh_max_active : TABLE_LIMIT;
		while (tbl_count < lim && stk_count > 0) begin
			stk_count--;
			tbl_file[tbl_count] = stk_file[stk_count];
			tbl_total[tbl_count] = stk_total[stk_count];
			tbl_next[tbl_count] = 16'd1;
			tbl_count++;
		end
		if (tbl_count == 0) return;
		if (rr_pos >= tbl_count) rr_pos = 0;
		r.request_valid = 1'b1;
		r.req_file = tbl_file[rr_pos];
		r.req_chunk = tbl_next[rr_pos];
		if (tbl_next[rr_pos] >= tbl_total[rr_pos]) begin
			for (int i = rr_pos; i + 1 < tbl_count; i++) begin
				tbl_file[i] = tbl_file[i + 1];
				tbl_total[i] = tbl_total[i + 1];
				tbl_next[i] = tbl_next[i + 1];
			end
			tbl_count--;
		end else begin
			tbl_next[rr_pos] = tbl_next[rr_pos] + 16'd1;
			rr_pos++;
		end
		if (pending != 16'hFFFF) pending = pending + 16'd1;
		if ({1'b0, pending} > {sh_window, 1'b0}) begin
			rate = rate >> 1;
		end else if (pending < (sh_window >> 1)) begin
			rate = ({rate, 1'b0} >= {1'b0, sh_max_rate}) ? sh_max_rate : {rate[30:0], 1'b0};
		end
	endtask

	task automatic predict_item(input cmd_t c, input logic [15:0] fid,
			input logic [15:0] tot, output result_t r);
		r = '0;
		case (c)
			CMD_PUSH: begin
				if (stk_count >= STACK_LIMIT) begin
					r.error_flag = 1'b1;
				end else begin
					stk_file[stk_count] = fid;
					stk_total[stk_count] = tot;
					stk_count++;
				end
			end
			CMD_REQ: begin
				next_request(r);
			end
			CMD_RET: begin
				if (pending == 0) r.error_flag = 1'b1;
				else pending = pending - 16'd1;
			end
			default: ;
		endcase
		r.send_rate = rate;
		r.outstanding = pending;
		r.all_done = (stk_count == 0 && tbl_count == 0);
	endtask

	// Drives one beat; valid stays high between back-to-back beats.
	task automatic send_beat(input cmd_t c, input logic [15:0] fid, input logic [15:0] tot,
			input bit typed, input result_t typed_r);
		int gap;
		result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c;
		s_axis_tdata <= {tot, fid};
		do @(posedge clk); while (!s_axis_tready);
		predict_item(c, fid, tot, r);
		if (typed) begin
			r.request_valid = typed_r.request_valid;
			r.all_done = typed_r.all_done;
			r.error_flag = typed_r.error_flag;
			if (typed_r.request_valid) begin
				r.req_file = typed_r.req_file;
				r.req_chunk = typed_r.req_chunk;
			end
		end
		expected_results.insert(expected_results.size(), r);
		n_items++;
		if (r.request_valid) n_issued++;
		if (r.error_flag) n_errors++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAX_ACTIVE: sh_max_active = val[4:0];
			REG_MAX_RATE: begin
				sh_max_rate = val;
				rate = val;
			end
			REG_WINDOW: sh_window = val[15:0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input longint unsigned e, input longint unsigned a);
		if (e != a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: %h", m_axis_tdata);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				check_field("request_valid", e.request_valid, m_axis_tdata[0]);
				check_field("req_file", e.req_file, m_axis_tdata[16:1]);
				check_field("req_chunk", e.req_chunk, m_axis_tdata[32:17]);
				check_field("send_rate", e.send_rate, m_axis_tdata[64:33]);
				check_field("outstanding", e.outstanding, m_axis_tdata[80:65]);
				check_field("all_done", e.all_done, m_axis_tdata[81]);
				check_field("error_flag", e.error_flag, m_axis_tdata[82]);
			end
		end
	end

	typedef struct {
		cmd_t c;
		logic [15:0] fid;
		logic [15:0] tot;
		bit typed;
		result_t r;
	} stim_row_t;

	function automatic result_t flags(bit v, logic [15:0] f, logic [15:0] ch, bit done, bit err);
		result_t r;
		r = '0;
		r.request_valid = v;
		r.req_file = f;
		r.req_chunk = ch;
		r.all_done = done;
		r.error_flag = err;
		return r;
	endfunction

	initial begin
		stim_row_t rows [$];
		cmd_t c;
		int roll;
		logic [15:0] tot;

		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_NOP;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_ACTIVE;
		cfg_data = '0;
		arst_n = 1'b0;
		sh_max_active = 5'd16;
		sh_max_rate = 32'd1000000000;
		sh_window = 16'd64;
		stk_count = 0;
		tbl_count = 0;
		rr_pos = 0;
		pending = '0;
		rate = sh_max_rate;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		rows = '{
			'{CMD_RET, 16'h0, 16'h0, 1, flags(0, 0, 0, 1, 1)},
			'{CMD_REQ, 16'h0, 16'h0, 1, flags(0, 0, 0, 1, 0)},
			'{CMD_NOP, 16'hFFFF, 16'hFFFF, 1, flags(0, 0, 0, 1, 0)},
			'{CMD_PUSH, 16'hFFFF, 16'h0, 1, flags(0, 0, 0, 0, 0)},
			'{CMD_REQ, 16'h0, 16'h0, 1, flags(1, 16'hFFFF, 16'd1, 1, 0)},
			'{CMD_PUSH, 16'h0, 16'hFFFF, 1, flags(0, 0, 0, 0, 0)},
			'{CMD_PUSH, 16'h1234, 16'd2, 0, '0},
			'{CMD_PUSH, 16'hABCD, 16'd1, 0, '0},
			'{CMD_REQ, 16'h0, 16'h0, 1, flags(1, 16'hABCD, 16'd1, 0, 0)},
			'{CMD_REQ, 16'h0, 16'h0, 0, '0},
			'{CMD_REQ, 16'h0, 16'h0, 0, '0},
			'{CMD_REQ, 16'h0, 16'h0, 0, '0},
			'{CMD_REQ, 16'h0, 16'h0, 0, '0},
			'{CMD_RET, 16'h5555, 16'hAAAA, 0, '0},
			'{CMD_RET, 16'h0, 16'h0, 0, '0},
			'{CMD_NOP, 16'h0, 16'h0, 0, '0}
		};
		foreach (rows[i]) send_beat(rows[i].c, rows[i].fid, rows[i].tot, rows[i].typed, rows[i].r);
		drain();

		// Fill the stack past its depth, then hold the sender until all results are in.
		for (int i = 0; i < 66; i++)
			send_beat(CMD_PUSH, 16'($urandom), 16'($urandom_range(3)), 0, '0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(REG_MAX_ACTIVE, 32'd1); write_reg(REG_MAX_RATE, 32'hFFFFFFFF);
					write_reg(REG_WINDOW, 32'd0); end
				1: begin write_reg(REG_MAX_ACTIVE, 32'd31); write_reg(REG_MAX_RATE, 32'd1);
					write_reg(REG_WINDOW, 32'hFFFF); end
				2: begin write_reg(REG_MAX_ACTIVE, 32'd0); write_reg(REG_MAX_RATE, 32'd0); end
				3: begin write_reg(REG_MAX_ACTIVE, 32'd4); write_reg(REG_MAX_RATE, 32'h5A5A5A5A);
					write_reg(REG_WINDOW, 32'd6); write_reg(REG_UNUSED, 32'hFFFFFFFF); end
				4: begin write_reg(REG_MAX_ACTIVE, 32'd16); write_reg(REG_WINDOW, 32'd2); end
				5: begin write_reg(REG_MAX_ACTIVE, 32'd15); write_reg(REG_MAX_RATE, 32'hA5A5A5A5);
					write_reg(REG_WINDOW, 32'd40); end
				6: begin write_reg(REG_MAX_ACTIVE, 32'd7); write_reg(REG_WINDOW, 32'd1); end
				default: begin write_reg(REG_MAX_ACTIVE, 32'd2); write_reg(REG_MAX_RATE, 32'd1000);
					write_reg(REG_WINDOW, 32'd9); end
			endcase
			gap_pct = (ph % 3 == 0) ? 0 : 35;
			stall_pct = (ph % 4 == 1) ? 0 : 40;
			for (int i = 0; i < 200; i++) begin
				roll = $urandom_range(99);
				// Returns are mixed in with requests so the outstanding count swings both ways.
				c = (roll < 35) ? CMD_PUSH : (roll < 78) ? CMD_REQ :
					(roll < 96) ? CMD_RET : CMD_NOP;
				tot = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
				send_beat(c, 16'($urandom), tot, 0, '0);
				if (i == 100 && ph == 5) drain();
			end
			drain();
		end

		$display("Covered %0d beats: %0d chunk requests issued, %0d error beats, %0d results.",
			n_items, n_issued, n_errors, n_results);
		if (fail_count == 0) begin
			$display("round_robin_chunk_requester_unit: match");
		end else begin
			$display("round_robin_chunk_requester_unit: mismatch");
		end
		$finish;
	end
endmodule
